### hdl/nearest_jet_cone_match_assert.svh
// assertion macros used by the checker
`ifndef NEAREST_JET_CONE_MATCH_ASSERT_SVH
`define NEAREST_JET_CONE_MATCH_ASSERT_SVH

// same-cycle implication, masked during reset
`define JCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define JCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/jcm_pkg.sv
`default_nettype none

package jcm_pkg;

  localparam int MAX_JETS        = 256;
  localparam int ANGLE_FRAC_BITS = 10;

  localparam int ETA_W      = 14;
  localparam int PHI_W      = 13;
  localparam int NUM_W      = 8;
  localparam int DIST_W     = 27;
  localparam int DETA_W     = ETA_W + 1;
  localparam int DPHI_W     = PHI_W;
  localparam int WRAP_W     = PHI_W + 3;
  localparam int DETA_SQ_W  = 28;
  localparam int DPHI_SQ_W  = 24;
  localparam int SUM_W      = DETA_SQ_W + 1;

  localparam longint unsigned PI_Q32 = 64'd13493037704;
  localparam logic signed [WRAP_W-1:0] PI_FX = WRAP_W'(
    (PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS));
  localparam logic signed [WRAP_W-1:0] TWO_PI_FX = WRAP_W'(
    (2 * PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS));

  localparam logic [DIST_W-1:0] DIST_MAX    = '1;
  localparam logic [DIST_W-1:0] CONE_RESET  = 27'd671089;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             take;
    logic [NUM_W-1:0] num;
  } ctl_t;

  typedef struct packed {
    logic [DIST_W-1:0] best_dist_sq;
    logic [NUM_W-1:0]  best_jet;
    logic              match_found;
  } result_t;

endpackage

`default_nettype wire

### hdl/jcm_delta.sv
`default_nettype none

module jcm_delta (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   load,
  input  jcm_pkg::ctl_t                         in_ctl,
  input  wire  signed [jcm_pkg::ETA_W-1:0]      parton_eta,
  input  wire  signed [jcm_pkg::PHI_W-1:0]      parton_phi,
  input  wire  signed [jcm_pkg::ETA_W-1:0]      jet_eta,
  input  wire  signed [jcm_pkg::PHI_W-1:0]      jet_phi,
  output jcm_pkg::ctl_t                         out_ctl,
  output logic signed [jcm_pkg::DETA_W-1:0]     deta,
  output logic signed [jcm_pkg::DPHI_W-1:0]     dphi
);

  logic signed [jcm_pkg::ETA_W-1:0]  ref_eta;
  logic signed [jcm_pkg::PHI_W-1:0]  ref_phi;
  logic signed [jcm_pkg::ETA_W-1:0]  use_eta;
  logic signed [jcm_pkg::PHI_W-1:0]  use_phi;
  logic signed [jcm_pkg::DETA_W-1:0] deta_next;
  logic signed [jcm_pkg::WRAP_W-1:0] dphi_raw;
  logic signed [jcm_pkg::WRAP_W-1:0] dphi_wrap;
  jcm_pkg::ctl_t                     ctl_next;

  always_comb begin
    use_eta   = in_ctl.first ? parton_eta : ref_eta;
    use_phi   = in_ctl.first ? parton_phi : ref_phi;
    deta_next = jcm_pkg::DETA_W'(jet_eta) - jcm_pkg::DETA_W'(use_eta);
    dphi_raw  = jcm_pkg::WRAP_W'(jet_phi) - jcm_pkg::WRAP_W'(use_phi);
    if (dphi_raw > jcm_pkg::PI_FX) begin
      dphi_wrap = dphi_raw - jcm_pkg::TWO_PI_FX;
    end else if (dphi_raw < -jcm_pkg::PI_FX) begin
      dphi_wrap = dphi_raw + jcm_pkg::TWO_PI_FX;
    end else begin
      dphi_wrap = dphi_raw;
    end
    ctl_next      = in_ctl;
    ctl_next.take = (32'(in_ctl.num) < jcm_pkg::MAX_JETS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_eta       <= '0;
      ref_phi       <= '0;
      out_ctl.valid <= 1'b0;
    end else if (load) begin
      if (in_ctl.valid && in_ctl.first) begin
        ref_eta <= parton_eta;
        ref_phi <= parton_phi;
      end
      out_ctl.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ctl.first <= ctl_next.first;
      out_ctl.last  <= ctl_next.last;
      out_ctl.take  <= ctl_next.take;
      out_ctl.num   <= ctl_next.num;
      deta          <= deta_next;
      dphi          <= jcm_pkg::DPHI_W'(dphi_wrap);
    end
  end

endmodule

`default_nettype wire

### hdl/jcm_square.sv
`default_nettype none

module jcm_square (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                load,
  input  jcm_pkg::ctl_t                      in_ctl,
  input  wire  signed [jcm_pkg::DETA_W-1:0]  deta,
  input  wire  signed [jcm_pkg::DPHI_W-1:0]  dphi,
  output jcm_pkg::ctl_t                      out_ctl,
  output logic [jcm_pkg::DETA_SQ_W-1:0]      deta_sq,
  output logic [jcm_pkg::DPHI_SQ_W-1:0]      dphi_sq
);

  logic signed [2*jcm_pkg::DETA_W-1:0] deta_prod;
  logic signed [2*jcm_pkg::DPHI_W-1:0] dphi_prod;

  always_comb begin
    deta_prod = deta * deta;
    dphi_prod = dphi * dphi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else if (load) begin
      out_ctl.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ctl.first <= in_ctl.first;
      out_ctl.last  <= in_ctl.last;
      out_ctl.take  <= in_ctl.take;
      out_ctl.num   <= in_ctl.num;
      deta_sq       <= deta_prod[jcm_pkg::DETA_SQ_W-1:0];
      dphi_sq       <= dphi_prod[jcm_pkg::DPHI_SQ_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hdl/jcm_track.sv
`default_nettype none

module jcm_track (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              retire,
  input  jcm_pkg::ctl_t                    in_ctl,
  input  wire  [jcm_pkg::DETA_SQ_W-1:0]    deta_sq,
  input  wire  [jcm_pkg::DPHI_SQ_W-1:0]    dphi_sq,
  input  wire  [jcm_pkg::DIST_W-1:0]       cone_radius_sq,
  output logic                             push,
  output jcm_pkg::result_t                 push_data
);

  logic [jcm_pkg::DIST_W-1:0] min_dist;
  logic [jcm_pkg::NUM_W-1:0]  min_index;
  logic [jcm_pkg::DIST_W-1:0] min_dist_next;
  logic [jcm_pkg::NUM_W-1:0]  min_index_next;
  logic [jcm_pkg::DIST_W-1:0] base_dist;
  logic [jcm_pkg::NUM_W-1:0]  base_index;
  logic [jcm_pkg::SUM_W-1:0]  sum;
  logic [jcm_pkg::DIST_W-1:0] jet_dist;

  always_comb begin
    sum      = jcm_pkg::SUM_W'(deta_sq) + jcm_pkg::SUM_W'(dphi_sq);
    jet_dist = (sum > jcm_pkg::SUM_W'(jcm_pkg::DIST_MAX)) ? jcm_pkg::DIST_MAX
                                                          : sum[jcm_pkg::DIST_W-1:0];
    base_dist  = in_ctl.first ? jcm_pkg::DIST_MAX : min_dist;
    base_index = in_ctl.first ? '0 : min_index;
    if (in_ctl.take && (in_ctl.first || jet_dist < base_dist)) begin
      min_dist_next  = jet_dist;
      min_index_next = in_ctl.num;
    end else begin
      min_dist_next  = base_dist;
      min_index_next = base_index;
    end
    push                   = retire && in_ctl.valid && in_ctl.last;
    push_data.match_found  = (min_dist_next < cone_radius_sq);
    push_data.best_jet     = min_index_next;
    push_data.best_dist_sq = min_dist_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist  <= jcm_pkg::DIST_MAX;
      min_index <= '0;
    end else if (retire && in_ctl.valid) begin
      if (in_ctl.last) begin
        min_dist  <= jcm_pkg::DIST_MAX;
        min_index <= '0;
      end else begin
        min_dist  <= min_dist_next;
        min_index <= min_index_next;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/jcm_outbuf.sv
`default_nettype none

module jcm_outbuf (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  jcm_pkg::result_t  push_data,
  input  wire               out_ready,
  output logic              out_valid,
  output jcm_pkg::result_t  out_data,
  output logic              spare_full
);

  jcm_pkg::result_t spare_data;
  logic             pop;

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      spare_full <= 1'b0;
    end else if (spare_full) begin
      if (pop) begin
        spare_full <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        spare_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_full) begin
      if (pop) begin
        out_data <= spare_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        spare_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/nearest_jet_cone_match.sv
// nearest jet search in eta-phi space for one reference parton
//
// jets arrive on the s_axis channel, one per beat; tuser marks the first jet
// of a search (its beat also carries the parton eta and phi), tlast the last.
// on the last beat one result leaves on m_axis: match flag, nearest jet index
// and the smallest squared distance. the cone register is written on the cfg
// channel, which is always ready; write it only while no search is running.
//
// one beat is accepted every cycle while s_axis_tready is high. the path is
// input register, delta and phi wrap, squaring, then the running-minimum
// update, whose result is registered in the result buffer on m_axis.
// a two-entry result buffer keeps beats flowing while the receiver stalls;
// s_axis_tready drops only when both entries are full and a last beat is
// waiting at the minimum stage.
// reset clears the reference, the running minimum and all valid flags, and
// loads the cone register with 0.8 squared.
`default_nettype none

module nearest_jet_cone_match (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // parton_eta, parton_phi, jet_eta, jet_phi, jet_number, zero fill
  input  wire  [63:0] s_axis_tdata,
  // first_jet
  input  wire         s_axis_tuser,
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // match_found, best_jet, best_dist_sq, zero fill
  output logic [39:0] m_axis_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [26:0] cfg_data
);

  logic [jcm_pkg::DIST_W-1:0] cone_radius_sq;

  jcm_pkg::ctl_t                     in_ctl;
  logic signed [jcm_pkg::ETA_W-1:0]  parton_eta;
  logic signed [jcm_pkg::PHI_W-1:0]  parton_phi;
  logic signed [jcm_pkg::ETA_W-1:0]  jet_eta;
  logic signed [jcm_pkg::PHI_W-1:0]  jet_phi;

  jcm_pkg::ctl_t                     dl_ctl;
  logic signed [jcm_pkg::DETA_W-1:0] deta;
  logic signed [jcm_pkg::DPHI_W-1:0] dphi;

  jcm_pkg::ctl_t                     sq_ctl;
  logic [jcm_pkg::DETA_SQ_W-1:0]     deta_sq;
  logic [jcm_pkg::DPHI_SQ_W-1:0]     dphi_sq;

  logic             push;
  jcm_pkg::result_t push_data;
  jcm_pkg::result_t out_data;
  logic             spare_full;

  logic retire;
  logic free_sq;
  logic free_dl;
  logic free_in;

  always_comb begin
    retire        = sq_ctl.valid && (!sq_ctl.last || !spare_full);
    free_sq       = !sq_ctl.valid || retire;
    free_dl       = !dl_ctl.valid || free_sq;
    free_in       = !in_ctl.valid || free_dl;
    s_axis_tready = free_in;
    cfg_ready     = 1'b1;
    m_axis_tdata  = {4'b0, out_data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cone_radius_sq <= jcm_pkg::CONE_RESET;
    end else if (cfg_valid) begin
      cone_radius_sq <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_ctl.valid <= 1'b0;
    end else if (free_in) begin
      in_ctl.valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (free_in) begin
      parton_eta    <= s_axis_tdata[13:0];
      parton_phi    <= s_axis_tdata[26:14];
      jet_eta       <= s_axis_tdata[40:27];
      jet_phi       <= s_axis_tdata[53:41];
      in_ctl.num    <= s_axis_tdata[61:54];
      in_ctl.first  <= s_axis_tuser;
      in_ctl.last   <= s_axis_tlast;
      in_ctl.take   <= 1'b0;
    end
  end

  jcm_delta u_delta (
    .clk        (clk),
    .rst        (rst),
    .load       (free_dl),
    .in_ctl     (in_ctl),
    .parton_eta (parton_eta),
    .parton_phi (parton_phi),
    .jet_eta    (jet_eta),
    .jet_phi    (jet_phi),
    .out_ctl    (dl_ctl),
    .deta       (deta),
    .dphi       (dphi)
  );

  jcm_square u_square (
    .clk     (clk),
    .rst     (rst),
    .load    (free_sq),
    .in_ctl  (dl_ctl),
    .deta    (deta),
    .dphi    (dphi),
    .out_ctl (sq_ctl),
    .deta_sq (deta_sq),
    .dphi_sq (dphi_sq)
  );

  jcm_track u_track (
    .clk            (clk),
    .rst            (rst),
    .retire         (retire),
    .in_ctl         (sq_ctl),
    .deta_sq        (deta_sq),
    .dphi_sq        (dphi_sq),
    .cone_radius_sq (cone_radius_sq),
    .push           (push),
    .push_data      (push_data)
  );

  jcm_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_data   (out_data),
    .spare_full (spare_full)
  );

endmodule

`default_nettype wire

### hdl/jcm_checker.sv
`default_nettype none

`include "nearest_jet_cone_match_assert.svh"

module jcm_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [63:0] s_axis_tdata,
  input wire        s_axis_tuser,
  input wire        s_axis_tlast,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata,
  input wire        cfg_valid,
  input wire        cfg_ready,
  input wire [26:0] cfg_data
);

  logic [jcm_pkg::DIST_W-1:0] cone_shadow;
  logic                       in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast
                   && (s_axis_tdata[63:62] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      cone_shadow <= jcm_pkg::CONE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cone_shadow <= cfg_data;
    end
  end

  // a stalled result holds
  `JCM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  `JCM_ASSERT_NOW(a_reset_clears, $past(rst), !m_axis_tvalid && s_axis_tready,
    "result or stall left over after reset")

  `JCM_ASSERT_NOW(a_match_flag, m_axis_tvalid,
    m_axis_tdata[0] == (m_axis_tdata[35:9] < cone_shadow),
    "match flag disagrees with cone radius")

  `JCM_ASSERT_NOW(a_fill_zero, m_axis_tvalid || in_beat,
    m_axis_tdata[39:36] == 4'b0000, "result fill bits not zero")

endmodule

bind nearest_jet_cone_match jcm_checker u_jcm_checker (.*);

`default_nettype wire
